// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the front end and queue modules of the reply frame builder.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is low.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, off while reset is low.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- hdl/rfb_pkg.sv -----
// Types and constants of the reply frame builder.
package rfb_pkg;

  localparam int CNT_W = 3;          // holds a repeat count of up to 7
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] START_RESET = 8'h40;
  localparam logic [7:0] END_RESET   = 8'h23;
  localparam logic [7:0] SEP_RESET   = 8'h3E;
  localparam logic [7:0] LINE_FEED   = 8'h0A;
  localparam logic [7:0] ALL_ONES    = 8'hFF;
  localparam logic [7:0] SPLIT_TAIL  = 8'h01;

  typedef enum logic [1:0] {
    REG_START = 2'd0,
    REG_END   = 2'd1,
    REG_SEP   = 2'd2,
    REG_MODE  = 2'd3
  } reg_addr_e;

  typedef enum logic [5:0] {
    PH_OPEN = 6'b000001,
    PH_DATA = 6'b000010,
    PH_SEP  = 6'b000100,
    PH_CS   = 6'b001000,
    PH_TAIL = 6'b010000,
    PH_CLOSE = 6'b100000
  } phase_e;

  typedef struct packed {
    logic [7:0] start_char;
    logic [7:0] end_char;
    logic [7:0] sep_char;
    logic       checked;
  } cfg_t;

  // One classified input item, ready for the emitter.
  typedef struct packed {
    logic [7:0]       data_byte;
    logic             checked;
    logic [CNT_W-1:0] n_open;
    logic [CNT_W-1:0] n_close;
    logic [7:0]       cs;
    logic             cs_zero;
    logic             cs_split;
  } job_t;

endpackage

// ----- hdl/rfb_if.sv -----
// Stream interfaces of the reply frame builder: payload in, framed bytes out.
interface rfb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       is_last;
  modport source (output valid, output data_byte, output is_last, input ready);
  modport sink (input valid, input data_byte, input is_last, output ready);
endinterface

interface rfb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       run_end;
  modport source (output valid, output out_byte, output run_end, input ready);
  modport sink (input valid, input out_byte, input run_end, output ready);
endinterface

// ----- hdl/reply_frame_builder_top.sv -----
// Top level of the reply frame builder: register port, front end, queue, emitter.
//
// Usage: payload bytes enter on in_chan (data_byte, is_last), one per transfer.
// Framed bytes leave on out_chan (out_byte, run_end); run_end marks the last
// byte caused by one input transfer. Both channels transfer on valid and ready.
// The APB port writes start_char, end_char, sep_char and checked_mode at byte
// addresses 0, 4, 8 and 12; write them only while the block is idle.
// Each item's transfer is registered in the job queue, and its first output byte
// then in the output register. The emitter gives one output byte per cycle
// while the receiver does not stall; an item makes one byte for a body byte,
// up to 2*START_STOP_COUNT+4 at the frame ends. A plain body byte sustains
// one item per cycle while the receiver does not stall.
// Reset clears the registers to '@', '#', '>' and plain mode, closes any open
// frame and empties the two-entry job queue.
// When the receiver stalls, the output register holds its byte, the emitter
// stops, and in_chan.ready drops once the job queue is full.
module reply_frame_builder_top #(
  parameter int START_STOP_COUNT = 2
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rfb_in_if.sink      in_chan,
  rfb_out_if.source   out_chan,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import rfb_pkg::*;

  cfg_t      cfg_q;
  reg_addr_e reg_sel;
  logic      cfg_write;
  logic      push, full, pop, job_valid;
  job_t      job_in, job_out;

  assign pready    = 1'b1;
  assign reg_sel   = reg_addr_e'(paddr[3:2]);
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_char <= START_RESET;
      cfg_q.end_char   <= END_RESET;
      cfg_q.sep_char   <= SEP_RESET;
      cfg_q.checked    <= 1'b0;
    end else if (cfg_write) begin
      unique case (reg_sel)
        REG_START: cfg_q.start_char <= pwdata[7:0];
        REG_END:   cfg_q.end_char   <= pwdata[7:0];
        REG_SEP:   cfg_q.sep_char   <= pwdata[7:0];
        REG_MODE:  cfg_q.checked    <= pwdata[0];
        default:   cfg_q.checked    <= cfg_q.checked;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_START: prdata = {24'd0, cfg_q.start_char};
      REG_END:   prdata = {24'd0, cfg_q.end_char};
      REG_SEP:   prdata = {24'd0, cfg_q.sep_char};
      REG_MODE:  prdata = {31'd0, cfg_q.checked};
      default:   prdata = 32'd0;
    endcase
  end

  rfb_front #(
    .START_STOP_COUNT(START_STOP_COUNT)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_chan (in_chan),
    .cfg_i   (cfg_q),
    .full_i  (full),
    .push_o  (push),
    .job_o   (job_in)
  );

  rfb_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (job_in),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (job_valid),
    .job_o   (job_out)
  );

  rfb_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .valid_i  (job_valid),
    .job_i    (job_out),
    .pop_o    (pop),
    .out_chan (out_chan)
  );
endmodule

// ----- hdl/rfb_front.sv -----
// Front end: accepts payload bytes, tracks the frame and checksum, builds jobs.
`include "assert_macros.svh"
module rfb_front #(
  parameter int START_STOP_COUNT = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  rfb_in_if.sink         in_chan,
  input  rfb_pkg::cfg_t  cfg_i,
  input  logic           full_i,
  output logic           push_o,
  output rfb_pkg::job_t  job_o
);
  import rfb_pkg::*;

  logic [7:0]       sum_q, sum_d;
  logic             inside_q, inside_d;
  logic [CNT_W-1:0] reps;
  logic [7:0]       cs;

  assign in_chan.ready = !full_i;
  assign push_o = in_chan.valid && !full_i;

  always_comb begin
    reps = cfg_i.checked ? CNT_W'(START_STOP_COUNT) : CNT_W'(1);
    sum_d = (inside_q ? sum_q : 8'd0) + in_chan.data_byte;
    cs = 8'd0 - sum_d - cfg_i.sep_char;
    inside_d = !in_chan.is_last;

    job_o.data_byte = in_chan.data_byte;
    job_o.checked   = cfg_i.checked;
    job_o.n_open    = inside_q ? '0 : reps;
    job_o.n_close   = in_chan.is_last ? reps : '0;
    job_o.cs        = cs;
    job_o.cs_zero   = (cs == 8'd0);
    job_o.cs_split  = (cs == cfg_i.start_char) || (cs == cfg_i.end_char) ||
                      (cs == cfg_i.sep_char) || (cs == LINE_FEED) || (cs == ALL_ONES);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= 8'd0;
      inside_q <= 1'b0;
    end else if (push_o) begin
      sum_q    <= sum_d;
      inside_q <= inside_d;
    end
  end

  `ASSERT_NEXT(a_last_closes_frame, clk_i, rst_ni, push_o && in_chan.is_last, !inside_q)
  `ASSERT_NEXT(a_body_keeps_frame, clk_i, rst_ni, push_o && !in_chan.is_last, inside_q)
endmodule

// ----- hdl/rfb_queue.sv -----
// Two-entry job queue between the front end and the emitter.
`include "assert_macros.svh"
module rfb_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  rfb_pkg::job_t  job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output rfb_pkg::job_t  job_o
);
  import rfb_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_QW = $clog2(QUEUE_DEPTH+1);

  job_t                   mem_q [QUEUE_DEPTH];
  logic [PTR_W-1:0]       wr_q, rd_q;
  logic [CNT_QW-1:0]      cnt_q;

  assign full_o  = (cnt_q == CNT_QW'(QUEUE_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + CNT_QW'(1);
        2'b01:   cnt_q <= cnt_q - CNT_QW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  `ASSERT_IMPLY(a_no_pop_empty, clk_i, rst_ni, pop_i, valid_o)
  `ASSERT_IMPLY(a_no_push_full, clk_i, rst_ni, push_i, !full_o)
endmodule

// ----- hdl/rfb_back.sv -----
// Emitter: walks one job through its framing bytes into the output register.
module rfb_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rfb_pkg::cfg_t  cfg_i,
  input  logic           valid_i,
  input  rfb_pkg::job_t  job_i,
  output logic           pop_o,
  rfb_out_if.source      out_chan
);
  import rfb_pkg::*;

  phase_e           phase_q, phase_d, cur_phase;
  logic [CNT_W-1:0] cnt_q, cnt_d, cur_cnt, cnt_inc;
  logic             fresh_q;
  logic             out_valid_q;
  logic [7:0]       out_byte_q, byte_d;
  logic             run_end_q;
  logic             emit, done;

  assign emit  = valid_i && (!out_valid_q || out_chan.ready);
  assign pop_o = emit && done;

  assign out_chan.valid    = out_valid_q;
  assign out_chan.out_byte = out_byte_q;
  assign out_chan.run_end  = run_end_q;

  always_comb begin
    cur_phase = fresh_q ? ((job_i.n_open != '0) ? PH_OPEN : PH_DATA) : phase_q;
    cur_cnt   = fresh_q ? '0 : cnt_q;
    cnt_inc   = cur_cnt + CNT_W'(1);
    byte_d    = job_i.data_byte;
    phase_d   = cur_phase;
    cnt_d     = cur_cnt;
    done      = 1'b0;
    unique case (cur_phase)
      PH_OPEN: begin
        byte_d = cfg_i.start_char;
        if (cnt_inc == job_i.n_open) begin
          phase_d = PH_DATA;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      PH_DATA: begin
        byte_d = job_i.data_byte;
        if (job_i.n_close == '0) begin
          done = 1'b1;
        end else begin
          phase_d = job_i.checked ? PH_SEP : PH_CLOSE;
        end
      end
      PH_SEP: begin
        byte_d  = cfg_i.sep_char;
        phase_d = job_i.cs_zero ? PH_CLOSE : PH_CS;
      end
      PH_CS: begin
        // escape a checksum that collides with a framing character
        byte_d  = job_i.cs_split ? job_i.cs - 8'd1 : job_i.cs;
        phase_d = job_i.cs_split ? PH_TAIL : PH_CLOSE;
      end
      PH_TAIL: begin
        byte_d  = SPLIT_TAIL;
        phase_d = PH_CLOSE;
      end
      PH_CLOSE: begin
        byte_d = cfg_i.end_char;
        if (cnt_inc == job_i.n_close) begin
          done  = 1'b1;
          cnt_d = '0;
        end else begin
          cnt_d = cnt_inc;
        end
      end
      default: begin
        byte_d = job_i.data_byte;
        done   = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_DATA;
      cnt_q       <= '0;
      fresh_q     <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        phase_q     <= phase_d;
        cnt_q       <= cnt_d;
        fresh_q     <= done;
        out_valid_q <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      out_byte_q <= byte_d;
      run_end_q  <= done;
    end
  end
endmodule

// ----- test/tb_top.sv -----
// Testbench of reply_frame_builder_top: directed and random replies checked against a frame predictor.
`timescale 1ns / 100ps

module tb_top;
  import rfb_pkg::*;

  localparam int REPS = 2;
  localparam int IDLE_LIMIT = 1000;
  localparam int SETTLE_CYCLES = 12;

  typedef struct {
    logic [7:0] out_byte;
    logic       run_end;
  } framed_byte_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  rfb_in_if  in_chan ();
  rfb_out_if out_chan ();

  reply_frame_builder_top #(
    .START_STOP_COUNT(REPS)
  ) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Predictor copy of the registers and the frame state.
  logic [7:0] cfg_start = START_RESET;
  logic [7:0] cfg_end   = END_RESET;
  logic [7:0] cfg_sep   = SEP_RESET;
  logic       cfg_checked = 1'b0;
  logic [7:0] run_sum = 8'h00;
  logic       frame_open = 1'b0;

  framed_byte_t frame_q[$];
  int errors = 0;
  int idle_cycles = 0;
  int burst_left = 0;
  logic gaps_on = 1'b1;

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  function automatic logic cs_collides(input logic [7:0] cs);
    return cs == cfg_start || cs == cfg_end || cs == cfg_sep ||
           cs == LINE_FEED || cs == ALL_ONES;
  endfunction

  // Last byte that makes the open (or next) frame's checksum come out as target.
  function automatic logic [7:0] byte_for_cs(input logic [7:0] target);
    logic [7:0] b;
    b = 8'h00 - run_sum - cfg_sep - target;
    return b;
  endfunction

  task automatic push_byte(input logic [7:0] b);
    framed_byte_t fb;
    fb.out_byte = b;
    fb.run_end = 1'b0;
    frame_q.push_back(fb);
  endtask

  task automatic predict_frame_bytes(input logic [7:0] b, input logic last);
    int reps;
    logic [7:0] cs;
    framed_byte_t fb;
    reps = cfg_checked ? REPS : 1;
    if (!frame_open) begin
      for (int i = 0; i < reps; i++) push_byte(cfg_start);
      run_sum = 8'h00;
      frame_open = 1'b1;
    end
    push_byte(b);
    run_sum = run_sum + b;
    if (last) begin
      if (cfg_checked) begin
        cs = 8'h00 - run_sum - cfg_sep;
        push_byte(cfg_sep);
        if (cs != 8'h00) begin
          if (cs_collides(cs)) begin
            push_byte(cs - 8'h01);
            push_byte(SPLIT_TAIL);
          end else begin
            push_byte(cs);
          end
        end
      end
      for (int i = 0; i < reps; i++) push_byte(cfg_end);
      run_sum = 8'h00;
      frame_open = 1'b0;
    end
    fb = frame_q.pop_back();
    fb.run_end = 1'b1;
    frame_q.push_back(fb);
  endtask

  // Offer one payload byte, idling first when gaps are on and a burst is used up.
  task automatic send_payload(input logic [7:0] b, input logic last);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 8);
      burst_left = $urandom_range(1, 12);
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    if (burst_left > 0) burst_left--;
    in_chan.valid <= 1'b1;
    in_chan.data_byte <= b;
    in_chan.is_last <= last;
    do @(posedge clk_i); while (!in_chan.ready);
    predict_frame_bytes(b, last);
  endtask

  // Drop valid, wait for every expected byte, then let the pipeline settle.
  task automatic drain_and_hold();
    in_chan.valid <= 1'b0;
    @(posedge clk_i);
    while (frame_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_addr_e idx, input logic [7:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'h000000, val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_START: cfg_start = val;
      REG_END:   cfg_end = val;
      REG_SEP:   cfg_sep = val;
      REG_MODE:  cfg_checked = val[0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 4))
      0: return 8'h00;
      1: return 8'hFF;
      2: return LINE_FEED;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Receiver: stall in runs, with long stretches of no stall; check each transfer.
  always @(posedge clk_i) begin : rx_side
    framed_byte_t want;
    static int stall_left = 0;
    static int stretch = 0;
    static logic calm = 1'b0;
    if (!rst_ni) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        if (frame_q.size() == 0) begin
          $display("%0t: unexpected byte: expected none, actual %h run_end %b",
                   $time, out_chan.out_byte, out_chan.run_end);
          errors++;
        end else begin
          want = frame_q.pop_front();
          if (want.out_byte !== out_chan.out_byte) begin
            $display("%0t: out_byte mismatch: expected %h, actual %h",
                     $time, want.out_byte, out_chan.out_byte);
            errors++;
          end
          if (want.run_end !== out_chan.run_end) begin
            $display("%0t: run_end mismatch: expected %b, actual %b",
                     $time, want.run_end, out_chan.run_end);
            errors++;
          end
        end
      end
      if (stretch == 0) begin
        stretch = $urandom_range(50, 300);
        calm = ($urandom_range(0, 2) == 0);
      end
      stretch--;
      if (stall_left > 0) begin
        stall_left--;
        out_chan.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        stall_left = $urandom_range(0, 7);
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when nothing transfers for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
          (psel && penable)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("reply_frame_builder_top verification failed");
        $finish;
      end
    end
  end

  task automatic test_plain_frames();
    send_payload(8'h00, 1'b1);
    send_payload(8'hFF, 1'b0);
    send_payload(8'h80, 1'b0);
    send_payload(8'h00, 1'b1);
    drain_and_hold();
  endtask

  task automatic test_checksum_cases();
    write_reg(REG_MODE, 8'h01);
    send_payload(byte_for_cs(8'h00), 1'b1);
    send_payload(byte_for_cs(cfg_start), 1'b1);
    send_payload(byte_for_cs(cfg_end), 1'b1);
    send_payload(byte_for_cs(cfg_sep), 1'b1);
    send_payload(byte_for_cs(LINE_FEED), 1'b1);
    send_payload(byte_for_cs(ALL_ONES), 1'b1);
    send_payload(byte_for_cs(8'h55), 1'b1);
    send_payload(8'h01, 1'b0);
    send_payload(byte_for_cs(8'h37), 1'b1);
    drain_and_hold();
  endtask

  // Change mode and delimiters while a frame is open but the block is idle.
  task automatic test_changes_in_frame();
    write_reg(REG_MODE, 8'h00);
    send_payload(8'h11, 1'b0);
    drain_and_hold();
    write_reg(REG_MODE, 8'h01);
    send_payload(8'h22, 1'b1);
    send_payload(8'h33, 1'b0);
    drain_and_hold();
    write_reg(REG_MODE, 8'h00);
    send_payload(8'h44, 1'b1);
    drain_and_hold();
    write_reg(REG_MODE, 8'h01);
    send_payload(8'h10, 1'b0);
    drain_and_hold();
    write_reg(REG_START, 8'h00);
    write_reg(REG_END, 8'hFF);
    write_reg(REG_SEP, 8'hFF);
    send_payload(byte_for_cs(ALL_ONES), 1'b1);
    drain_and_hold();
    write_reg(REG_START, 8'hFF);
    write_reg(REG_END, 8'h00);
    write_reg(REG_SEP, 8'h00);
    send_payload(byte_for_cs(8'hFF), 1'b1);
    send_payload(byte_for_cs(8'h00), 1'b1);
    drain_and_hold();
  endtask

  task automatic test_random_replies();
    int reply_left;
    logic last;
    logic [7:0] b;
    logic [7:0] target;
    reply_left = 0;
    for (int phase = 0; phase < 8; phase++) begin
      drain_and_hold();
      if (phase == 0) begin
        write_reg(REG_START, 8'h00);
        write_reg(REG_END, 8'h00);
        write_reg(REG_SEP, 8'h00);
      end else if (phase == 7) begin
        write_reg(REG_START, 8'hFF);
        write_reg(REG_END, 8'hFF);
        write_reg(REG_SEP, 8'hFF);
      end else begin
        write_reg(REG_START, pick_char());
        write_reg(REG_END, pick_char());
        write_reg(REG_SEP, pick_char());
      end
      write_reg(REG_MODE, (phase % 4 == 3) ? 8'h00 : 8'($urandom_range(0, 1)));
      gaps_on = (phase % 3 != 1);
      for (int k = 0; k < 18; k++) begin
        if (reply_left == 0) begin
          reply_left = ($urandom_range(0, 7) == 0) ? 12 : $urandom_range(1, 6);
        end
        last = (reply_left == 1);
        // Some noise: a reply cut short or run on.
        if ($urandom_range(0, 9) == 0) last = ~last;
        reply_left = last ? 0 : (reply_left > 1 ? reply_left - 1 : 0);
        b = 8'($urandom_range(0, 255));
        if (last && cfg_checked && $urandom_range(0, 2) == 0) begin
          case ($urandom_range(0, 5))
            0: target = cfg_start;
            1: target = cfg_end;
            2: target = cfg_sep;
            3: target = LINE_FEED;
            4: target = ALL_ONES;
            default: target = 8'h00;
          endcase
          b = byte_for_cs(target);
        end
        send_payload(b, last);
        if ($urandom_range(0, 39) == 0) drain_and_hold();
      end
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 4'h0;
    pwdata = 32'h0;
    in_chan.valid = 1'b0;
    in_chan.data_byte = 8'h00;
    in_chan.is_last = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_plain_frames();
    test_checksum_cases();
    test_changes_in_frame();
    test_random_replies();
    drain_and_hold();
    if (errors == 0) begin
      $display("reply_frame_builder_top verification clean");
    end else begin
      $display("reply_frame_builder_top verification failed");
    end
    $finish;
  end

endmodule
